// File: rtl/fst_pkg.sv
// shared types and constants of the frame sequence timer
`timescale 1ns / 1ps

package fst_pkg;

  // width of time stamps and of elapsed time
  localparam int EL_W = 32;

  typedef enum logic [2:0] {
    MODE_TICK      = 3'd0,
    MODE_PLAY      = 3'd1,
    MODE_SET       = 3'd2,
    MODE_STOP      = 3'd3,
    MODE_PAUSE     = 3'd4,
    MODE_RESUME    = 3'd5,
    MODE_LOAD_DUR  = 3'd6,
    MODE_LOAD_INFO = 3'd7
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_WALK,
    ST_SUM,
    ST_MOD,
    ST_REPLY
  } state_t;

  typedef struct packed {
    mode_t       mode;
    logic [31:0] now_time;
    logic [2:0]  seq_index;
    logic [5:0]  frame_index;
    logic [15:0] duration;
    logic        restart;
    logic        once;
    logic [6:0]  count_in;
    logic        loop_in;
  } fst_in_t;

  typedef struct packed {
    logic [2:0] cur_sequence;
    logic [5:0] cur_frame;
    logic       playing;
    logic       finished;
    logic       frame_changed;
    logic       completed_pulse;
    logic       accepted;
  } fst_out_t;

endpackage

// File: rtl/fst_stream_if.sv
// valid/ready stream channel carrying one payload per beat
`timescale 1ns / 1ps

interface fst_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// File: rtl/fst_ram.sv
// generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps

module fst_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/fst_rem.sv
// bit-serial restoring remainder unit, one dividend bit per cycle
`timescale 1ns / 1ps

module fst_rem #(
  parameter int DIV_W = 23
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [fst_pkg::EL_W-1:0] dividend,
  input  logic [DIV_W-1:0]         divisor,
  output logic                     done,
  output logic [DIV_W-1:0]         rem
);
  import fst_pkg::*;

  localparam int IDX_W = $clog2(EL_W);

  logic             busy;
  logic [IDX_W-1:0] idx;
  logic [EL_W-1:0]  quo;
  logic [DIV_W-1:0] dsr;
  logic [DIV_W:0]   trial;
  logic [DIV_W:0]   diff;

  // shift in the next dividend bit and try one subtraction
  always_comb begin
    trial = {rem, quo[EL_W-1]};
    diff  = trial - {1'b0, dsr};
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      idx  <= '0;
    end else begin
      done <= busy && (idx == '0);
      if (start) begin
        busy <= 1'b1;
        idx  <= IDX_W'(EL_W - 1);
      end else if (busy) begin
        if (idx == '0) begin
          busy <= 1'b0;
        end
        idx <= idx - 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      dsr <= divisor;
      rem <= '0;
    end else if (busy) begin
      quo <= {quo[EL_W-2:0], 1'b0};
      if (trial >= {1'b0, dsr}) begin
        rem <= diff[DIV_W-1:0];
      end else begin
        rem <= trial[DIV_W-1:0];
      end
    end
  end

endmodule

// File: rtl/frame_sequence_timer_top.sv
// frame sequence timer: sprite animation sequencer over a duration RAM
//
//   channel  | dir | payload    | beat
//   ---------+-----+------------+------------------------------------
//   items    | in  | fst_in_t   | one command, load or tick
//   results  | out | fst_out_t  | one result for every item taken
//
// commands, loads and idle ticks pass through accept, execute and reply.
// a tick that walks adds a walk step between execute and reply, with one duration
// RAM read per frame it steps over; a tick that wraps a looping run also sums the
// frame durations of the sequence and then reduces the elapsed time with the
// bit-serial remainder.
// reset clears counts, loop flags and play state at once; durations are
// undefined until loaded. a new item is taken while the last result waits;
// a stalled result holds the block in its reply step.
`timescale 1ns / 1ps

module frame_sequence_timer_top #(
  parameter int NUM_SEQUENCES = 8,
  parameter int MAX_FRAMES    = 64,
  parameter int DURATION_BITS = 16
) (
  input logic         clk,
  input logic         rst,
  fst_stream_if.sink   items,
  fst_stream_if.source results
);
  import fst_pkg::*;

  localparam int SEQ_W  = (NUM_SEQUENCES > 1) ? $clog2(NUM_SEQUENCES) : 1;
  localparam int FRAME_W = $clog2(MAX_FRAMES);
  localparam int CNT_W  = $clog2(MAX_FRAMES + 1);
  localparam int DUR_W  = DURATION_BITS;
  localparam int ADDR_W = SEQ_W + FRAME_W;
  localparam int DEPTH  = 1 << ADDR_W;
  localparam int TOT_W  = DUR_W + FRAME_W + 1;

  state_t state, state_next;

  // latched item
  fst_in_t itm;

  // play state
  logic [SEQ_W-1:0]   active_seq;
  logic [FRAME_W-1:0] active_frame;
  logic [EL_W-1:0]    frame_start;
  logic               run_flag;
  logic               done_flag;
  logic               once_flag;
  logic [CNT_W-1:0]   seq_counts [NUM_SEQUENCES];
  logic               seq_loop [NUM_SEQUENCES];

  // walk state
  logic [FRAME_W-1:0] walk_f;
  logic [EL_W-1:0]    el;
  logic               adv;
  logic               wrapped;
  logic [FRAME_W-1:0] sum_idx;
  logic [TOT_W-1:0]   total;

  // result flags and output register
  logic     res_changed;
  logic     res_pulse;
  logic     res_accepted;
  logic     out_valid;
  fst_out_t out_pay;

  // decode helpers
  logic [SEQ_W-1:0]   seq_sel;
  logic [FRAME_W-1:0] fidx_sel;
  logic               seq_ok;
  logic               fidx_ok;
  logic [SEQ_W-1:0]   cnt_sel;
  logic [CNT_W-1:0]   cnt_rd;
  logic               loop_on;
  logic [CNT_W-1:0]   cnt_load;
  logic [DUR_W-1:0]   dur_load;
  logic               tick_go;
  logic               frame_past;
  logic [EL_W-1:0]    start_eff;

  // walk helpers
  logic [DUR_W-1:0]   ram_rdata;
  logic [DUR_W-1:0]   d_eff;
  logic               take;
  logic [CNT_W-1:0]   f_inc;
  logic               at_end;
  logic [CNT_W-1:0]   sum_inc;
  logic               sum_last;
  logic [TOT_W-1:0]   total_next;

  // control strobes
  logic               in_ready;
  logic               load_out;
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [ADDR_W-1:0]  ram_raddr;
  logic               rem_start;
  logic               rem_done;
  logic [TOT_W-1:0]   rem_val;

  // decode of the latched item
  always_comb begin
    seq_sel    = SEQ_W'(itm.seq_index);
    fidx_sel   = FRAME_W'(itm.frame_index);
    seq_ok     = 32'(itm.seq_index) < NUM_SEQUENCES;
    fidx_ok    = 32'(itm.frame_index) < MAX_FRAMES;
    cnt_sel    = (itm.mode == MODE_TICK || itm.mode == MODE_RESUME) ? active_seq : seq_sel;
    cnt_rd     = seq_counts[cnt_sel];
    loop_on    = seq_loop[active_seq] && !once_flag;
    cnt_load   = (32'(itm.count_in) > MAX_FRAMES) ? CNT_W'(MAX_FRAMES)
                                                   : CNT_W'(itm.count_in);
    dur_load   = (DUR_W'(itm.duration) == '0) ? DUR_W'(1) : DUR_W'(itm.duration);
    tick_go    = run_flag && (cnt_rd >= CNT_W'(2));
    frame_past = CNT_W'(active_frame) >= cnt_rd;
    start_eff  = (frame_start == '0) ? itm.now_time : frame_start;
  end

  // one frame step against the duration read last cycle
  always_comb begin
    d_eff      = (ram_rdata == '0) ? DUR_W'(1) : ram_rdata;
    take       = el >= EL_W'(d_eff);
    f_inc      = CNT_W'(walk_f) + CNT_W'(1);
    at_end     = f_inc >= cnt_rd;
    sum_inc    = CNT_W'(sum_idx) + CNT_W'(1);
    sum_last   = sum_inc >= cnt_rd;
    total_next = total + TOT_W'(d_eff);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (items.valid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (itm.mode == MODE_TICK && tick_go && !frame_past) begin
          state_next = ST_WALK;
        end else begin
          state_next = ST_REPLY;
        end
      end
      ST_WALK: begin
        if (!take) begin
          state_next = ST_REPLY;
        end else if (!wrapped && at_end) begin
          state_next = loop_on ? ST_SUM : ST_REPLY;
        end
      end
      ST_SUM: begin
        if (sum_last) begin
          state_next = ST_MOD;
        end
      end
      ST_MOD: begin
        if (rem_done) begin
          state_next = ST_WALK;
        end
      end
      ST_REPLY: begin
        if (!out_valid || results.ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control strobes and RAM addressing
  always_comb begin
    in_ready  = 1'b0;
    load_out  = 1'b0;
    ram_we    = 1'b0;
    rem_start = 1'b0;
    ram_waddr = {seq_sel, fidx_sel};
    ram_raddr = {active_seq, walk_f};
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_EXEC: begin
        ram_we    = (itm.mode == MODE_LOAD_DUR) && seq_ok && fidx_ok;
        ram_raddr = {active_seq, active_frame};
      end
      ST_WALK: begin
        if (!wrapped && at_end) begin
          ram_raddr = {active_seq, FRAME_W'(0)};
        end else begin
          ram_raddr = {active_seq, FRAME_W'(f_inc)};
        end
      end
      ST_SUM: begin
        ram_raddr = {active_seq, FRAME_W'(sum_inc)};
        rem_start = sum_last;
      end
      ST_MOD: begin
        ram_raddr = {active_seq, FRAME_W'(0)};
      end
      ST_REPLY: begin
        load_out = !out_valid || results.ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // state register, play state and sequence table
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      active_seq   <= '0;
      active_frame <= '0;
      frame_start  <= '0;
      run_flag     <= 1'b0;
      done_flag    <= 1'b0;
      once_flag    <= 1'b0;
      out_valid    <= 1'b0;
      for (int i = 0; i < NUM_SEQUENCES; i++) begin
        seq_counts[i] <= '0;
        seq_loop[i]   <= 1'b0;
      end
    end else begin
      state <= state_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_EXEC: begin
          case (itm.mode)
            MODE_TICK: begin
              if (tick_go) begin
                if (frame_past) begin
                  active_frame <= '0;
                  frame_start  <= itm.now_time;
                end else begin
                  frame_start <= start_eff;
                end
              end
            end
            MODE_PLAY: begin
              if (seq_ok && cnt_rd != '0) begin
                if (itm.once || !(active_seq == seq_sel && run_flag && !itm.restart)) begin
                  active_seq   <= seq_sel;
                  active_frame <= '0;
                  frame_start  <= '0;
                  run_flag     <= 1'b1;
                  done_flag    <= 1'b0;
                  once_flag    <= itm.once;
                end
              end
            end
            MODE_SET: begin
              if (seq_ok && cnt_rd != '0) begin
                active_seq   <= seq_sel;
                active_frame <= '0;
                frame_start  <= '0;
                done_flag    <= 1'b0;
              end
            end
            MODE_STOP: begin
              run_flag     <= 1'b0;
              active_frame <= '0;
              done_flag    <= 1'b0;
            end
            MODE_PAUSE: begin
              run_flag <= 1'b0;
            end
            MODE_RESUME: begin
              if (cnt_rd != '0) begin
                run_flag <= 1'b1;
              end
            end
            MODE_LOAD_INFO: begin
              if (seq_ok) begin
                seq_counts[seq_sel] <= cnt_load;
                seq_loop[seq_sel]   <= itm.loop_in;
              end
            end
            default: begin
              run_flag <= run_flag;
            end
          endcase
        end
        ST_WALK: begin
          if (!take) begin
            // remainder settles inside the current frame
            if (adv) begin
              active_frame <= walk_f;
              frame_start  <= itm.now_time - el;
            end
          end else if (!wrapped && at_end && !loop_on) begin
            // non-looping run ends on its last frame
            active_frame <= FRAME_W'(cnt_rd - CNT_W'(1));
            frame_start  <= itm.now_time;
            run_flag     <= 1'b0;
            done_flag    <= 1'b1;
            once_flag    <= 1'b0;
          end
        end
        default: begin
          run_flag <= run_flag;
        end
      endcase
    end
  end

  // item latch, walk datapath and result payload
  always_ff @(posedge clk) begin
    if (in_ready && items.valid) begin
      itm <= items.payload;
    end
    if (load_out) begin
      out_pay.cur_sequence    <= 3'(active_seq);
      out_pay.cur_frame       <= 6'(active_frame);
      out_pay.playing         <= run_flag;
      out_pay.finished        <= done_flag;
      out_pay.frame_changed   <= res_changed;
      out_pay.completed_pulse <= res_pulse;
      out_pay.accepted        <= res_accepted;
    end
    case (state)
      ST_EXEC: begin
        res_changed  <= 1'b0;
        res_pulse    <= 1'b0;
        res_accepted <= 1'b1;
        walk_f       <= active_frame;
        el           <= itm.now_time - start_eff;
        adv          <= 1'b0;
        wrapped      <= 1'b0;
        case (itm.mode)
          MODE_TICK: begin
            res_changed <= tick_go && frame_past;
          end
          MODE_PLAY: begin
            if (!seq_ok || cnt_rd == '0) begin
              res_accepted <= 1'b0;
            end else begin
              res_changed <= itm.once ||
                             !(active_seq == seq_sel && run_flag && !itm.restart);
            end
          end
          MODE_SET: begin
            if (!seq_ok || cnt_rd == '0) begin
              res_accepted <= 1'b0;
            end else begin
              res_changed <= 1'b1;
            end
          end
          MODE_STOP: begin
            res_changed <= 1'b1;
          end
          MODE_RESUME: begin
            res_accepted <= cnt_rd != '0;
          end
          MODE_LOAD_DUR: begin
            res_accepted <= seq_ok && fidx_ok;
          end
          MODE_LOAD_INFO: begin
            res_accepted <= seq_ok;
          end
          default: begin
            res_accepted <= 1'b1;
          end
        endcase
      end
      ST_WALK: begin
        if (!take) begin
          res_changed <= adv;
        end else begin
          el  <= el - EL_W'(d_eff);
          adv <= 1'b1;
          if (!wrapped && at_end) begin
            if (loop_on) begin
              // wrap: sum the sequence, then reduce the remainder
              walk_f  <= '0;
              wrapped <= 1'b1;
              sum_idx <= '0;
              total   <= '0;
            end else begin
              res_changed <= 1'b1;
              res_pulse   <= 1'b1;
            end
          end else begin
            walk_f <= FRAME_W'(f_inc);
          end
        end
      end
      ST_SUM: begin
        total   <= total_next;
        sum_idx <= FRAME_W'(sum_inc);
      end
      ST_MOD: begin
        if (rem_done) begin
          el <= EL_W'(rem_val);
        end
      end
      default: begin
        adv <= adv;
      end
    endcase
  end

  // frame duration table; writes and walk reads never share a cycle
  fst_ram #(
    .WIDTH (DUR_W),
    .DEPTH (DEPTH)
  ) u_dur_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (dur_load),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // elapsed time modulo the sequence length
  fst_rem #(
    .DIV_W (TOT_W)
  ) u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (rem_start),
    .dividend (el),
    .divisor  (total_next),
    .done     (rem_done),
    .rem      (rem_val)
  );

  assign items.ready     = in_ready;
  assign results.valid   = out_valid;
  assign results.payload = out_pay;

endmodule
